[src/modbus_rtu_response_parser_unit_defines.svh]
// Assertion macros for the checker file of the Modbus RTU parser.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef MODBUS_RTU_RESPONSE_PARSER_UNIT_DEFINES_SVH
`define MODBUS_RTU_RESPONSE_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MRTU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modbus rtu parser: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define MRTU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modbus rtu parser: next-cycle check failed");

`endif

[src/mrtu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mrtu_pkg;

    // result event codes
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_READ_OK   = 3'd1;
    localparam logic [2:0] EV_WRITE_OK  = 3'd2;
    localparam logic [2:0] EV_CRC_ERR   = 3'd3;
    localparam logic [2:0] EV_COUNT_REJ = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_RPM_TO_MMS = 2'd0;
    localparam logic [1:0] CFG_READ_FUNC  = 2'd1;
    localparam logic [1:0] CFG_WRITE_FUNC = 2'd2;
    localparam logic [1:0] CFG_MAX_COUNT  = 2'd3;

    localparam logic [15:0] RST_RPM_TO_MMS = 16'd4152;
    localparam logic [7:0]  RST_READ_FUNC  = 8'd3;
    localparam logic [7:0]  RST_WRITE_FUNC = 8'd6;
    localparam logic [7:0]  RST_MAX_COUNT  = 8'd16;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // data bytes of a write-single-register echo ahead of its CRC
    localparam logic [7:0] WRITE_DATA_BYTES = 8'd4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
        logic [1:0] motor_enable;
    } in_t;

    typedef struct packed {
        logic [2:0]         event_res;
        logic               motor_index;
        logic signed [15:0] speed_rpm;
        logic signed [15:0] speed_mms;
        logic [15:0]        motor_frame_count;
        logic [15:0]        read_ok_count;
        logic [15:0]        write_ok_count;
        logic               error_flag;
    } out_t;

    typedef struct packed {
        logic [15:0] rpm_to_mms_q16;
        logic [7:0]  read_func_code;
        logic [7:0]  write_func_code;
        logic [7:0]  max_byte_count;
    } cfg_t;

    // one classified item handed from the parser to the result side
    typedef struct packed {
        logic [2:0]  ev;
        logic [1:0]  addr;
        logic [15:0] first_reg;
        logic [1:0]  motor_enable;
    } frame_t;

    // CRC-16/MODBUS, one byte, reflected
    function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[src/mrtu_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module mrtu_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire mrtu_pkg::frame_t push_data,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output mrtu_pkg::frame_t     pop_data
);

    mrtu_pkg::frame_t mem_reg [mrtu_pkg::QUEUE_DEPTH];

    logic [mrtu_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mrtu_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mrtu_pkg::QUEUE_CW-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign push_ready = (count_reg != mrtu_pkg::QUEUE_CW'(mrtu_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == mrtu_pkg::QUEUE_AW'(mrtu_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mrtu_pkg::QUEUE_AW'(mrtu_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[src/mrtu_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module mrtu_front #(
    parameter int NUM_MOTORS = 2
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            byte_valid,
    output logic                 byte_ready,
    input  wire mrtu_pkg::in_t    byte_item,
    input  wire mrtu_pkg::cfg_t   cfg,
    output logic                 push_valid,
    input  wire logic            push_ready,
    output mrtu_pkg::frame_t     push_frame
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FUNC  = 3'd1;
    localparam logic [2:0] ST_COUNT = 3'd2;
    localparam logic [2:0] ST_DATA  = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;
    localparam logic [2:0] ST_CRCL  = 3'd5;
    localparam logic [2:0] ST_CRCH  = 3'd6;
    localparam logic [2:0] ST_PARK  = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [7:0]  bcf_reg, bcf_next;
    logic [1:0]  addr_reg, addr_next;
    logic [15:0] first_reg, first_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] last2_reg, last2_next;
    logic [7:0]  cnt_inc;
    logic [7:0]  b;
    logic        accept;
    logic [2:0]  ev;

    assign byte_ready = push_ready;
    assign push_valid = byte_valid;
    assign accept     = byte_valid && push_ready;
    assign b          = byte_item.rx_byte;
    assign cnt_inc    = cnt_reg + 8'd1;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bcf_next   = bcf_reg;
        addr_next  = addr_reg;
        first_next = first_reg;
        crc_next   = crc_reg;
        last2_next = last2_reg;
        ev         = mrtu_pkg::EV_NONE;
        if (byte_item.func)
        begin
            // line gap: resync
            state_next = ST_IDLE;
            cnt_next   = '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if ((b >= 8'd1) && (b <= 8'(NUM_MOTORS)))
                    begin
                        addr_next  = 2'(b - 8'd1);
                        crc_next   = mrtu_pkg::crc_step(mrtu_pkg::CRC_INIT, b);
                        state_next = ST_FUNC;
                    end
                    else
                    begin
                        state_next = ST_PARK;
                    end
                end
                ST_FUNC:
                begin
                    crc_next = mrtu_pkg::crc_step(crc_reg, b);
                    cnt_next = '0;
                    if (b == cfg.read_func_code)
                    begin
                        state_next = ST_COUNT;
                    end
                    else if (b == cfg.write_func_code)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        state_next = ST_PARK;
                    end
                end
                ST_COUNT:
                begin
                    crc_next = mrtu_pkg::crc_step(crc_reg, b);
                    bcf_next = b;
                    cnt_next = '0;
                    if (b > cfg.max_byte_count)
                    begin
                        ev         = mrtu_pkg::EV_COUNT_REJ;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = (b == 8'd0) ? ST_CRCL : ST_DATA;
                    end
                end
                ST_DATA:
                begin
                    crc_next = mrtu_pkg::crc_step(crc_reg, b);
                    if (cnt_reg == 8'd0)
                    begin
                        first_next = {b, first_reg[7:0]};
                    end
                    else if (cnt_reg == 8'd1)
                    begin
                        first_next = {first_reg[15:8], b};
                    end
                    cnt_next = cnt_inc;
                    if (cnt_inc >= bcf_reg)
                    begin
                        state_next = ST_CRCL;
                    end
                end
                ST_CRCL:
                begin
                    // short frames pull the register out of the CRC bytes
                    if (bcf_reg == 8'd0)
                    begin
                        first_next = {b, first_reg[7:0]};
                    end
                    else if (bcf_reg == 8'd1)
                    begin
                        first_next = {first_reg[15:8], b};
                    end
                    last2_next = {8'h00, b};
                    state_next = ST_CRCH;
                end
                ST_CRCH:
                begin
                    if (bcf_reg == 8'd0)
                    begin
                        first_next = {first_reg[15:8], b};
                    end
                    last2_next = {b, last2_reg[7:0]};
                    ev         = ({b, last2_reg[7:0]} == crc_reg) ? mrtu_pkg::EV_READ_OK
                                                               : mrtu_pkg::EV_CRC_ERR;
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                ST_WRITE:
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc <= mrtu_pkg::WRITE_DATA_BYTES)
                    begin
                        crc_next = mrtu_pkg::crc_step(crc_reg, b);
                    end
                    else if (cnt_inc == mrtu_pkg::WRITE_DATA_BYTES + 8'd1)
                    begin
                        last2_next = {8'h00, b};
                    end
                    else
                    begin
                        last2_next = {b, last2_reg[7:0]};
                        ev         = ({b, last2_reg[7:0]} == crc_reg) ? mrtu_pkg::EV_WRITE_OK
                                                                   : mrtu_pkg::EV_CRC_ERR;
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
                default:
                begin
                    // parked: drop bytes until a gap
                end
            endcase
        end
    end

    always_comb
    begin
        push_frame.ev           = ev;
        push_frame.addr         = addr_next;
        push_frame.first_reg    = first_next;
        push_frame.motor_enable = byte_item.motor_enable;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            bcf_reg   <= '0;
            addr_reg  <= '0;
            first_reg <= '0;
            crc_reg   <= mrtu_pkg::CRC_INIT;
            last2_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            bcf_reg   <= bcf_next;
            addr_reg  <= addr_next;
            first_reg <= first_next;
            crc_reg   <= crc_next;
            last2_reg <= last2_next;
        end
    end

endmodule

`default_nettype wire

[src/mrtu_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module mrtu_back #(
    parameter int NUM_MOTORS = 2
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [15:0]     rpm_to_mms_q16,
    input  wire logic            pop_valid,
    output logic                 pop_ready,
    input  wire mrtu_pkg::frame_t pop_frame,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output mrtu_pkg::out_t       res_item
);

    // counters
    logic [15:0] rd_total_reg, rd_total_next;
    logic [15:0] wr_total_reg, wr_total_next;
    logic        err_reg, err_next;
    logic [15:0] motor_frames_reg [NUM_MOTORS];
    logic [15:0] motor_frames_next [NUM_MOTORS];

    // multiply stage
    logic               a_valid_reg;
    logic [2:0]         a_ev_reg;
    logic               a_idx_reg;
    logic signed [15:0] a_rpm_reg;
    logic               a_neg_reg;
    logic [31:0]        a_prod_reg;
    logic [15:0]        a_mcount_reg;
    logic [15:0]        a_rd_reg;
    logic [15:0]        a_wr_reg;
    logic               a_err_reg;

    // output register
    logic           res_valid_reg;
    mrtu_pkg::out_t res_item_reg;

    logic               out_free, a_free, take;
    logic               is_read, enabled;
    logic signed [15:0] rpm_raw, rpm_en, rpm_dir;
    logic [15:0]        mag;
    logic [31:0]        prod;
    logic [15:0]        mcount;
    logic [32:0]        rounded;
    logic [16:0]        v;
    logic signed [15:0] mms;

    assign out_free  = !res_valid_reg || res_ready;
    assign a_free    = !a_valid_reg || out_free;
    assign pop_ready = a_free;
    assign take      = pop_valid && a_free;
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // speed after enable and direction rules, then its magnitude times the factor
    always_comb
    begin
        is_read = (pop_frame.ev == mrtu_pkg::EV_READ_OK);
        enabled = ((pop_frame.addr == 2'd0) && pop_frame.motor_enable[0])
               || ((pop_frame.addr == 2'd1) && pop_frame.motor_enable[1]);
        rpm_raw = signed'(pop_frame.first_reg);
        rpm_en  = (enabled && is_read) ? rpm_raw : 16'sd0;
        rpm_dir = pop_frame.addr[0] ? 16'(-rpm_en) : rpm_en;
        mag     = rpm_dir[15] ? 16'(-rpm_dir) : unsigned'(rpm_dir);
        prod    = 32'(mag) * 32'(rpm_to_mms_q16);
    end

    always_comb
    begin
        rd_total_next = rd_total_reg;
        wr_total_next = wr_total_reg;
        err_next      = err_reg;
        mcount        = '0;
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            motor_frames_next[i] = motor_frames_reg[i];
        end
        case (pop_frame.ev)
            mrtu_pkg::EV_READ_OK:
            begin
                rd_total_next = rd_total_reg + 16'd1;
                err_next      = 1'b0;
                for (int i = 0; i < NUM_MOTORS; i++)
                begin
                    if (32'(pop_frame.addr) == i)
                    begin
                        motor_frames_next[i] = motor_frames_reg[i] + 16'd1;
                        mcount               = motor_frames_reg[i] + 16'd1;
                    end
                end
            end
            mrtu_pkg::EV_WRITE_OK:
            begin
                wr_total_next = wr_total_reg + 16'd1;
            end
            mrtu_pkg::EV_CRC_ERR:
            begin
                err_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // round half away from zero, then saturate
    always_comb
    begin
        rounded = {1'b0, a_prod_reg} + 33'h0_0000_8000;
        v       = rounded[32:16];
        if (!a_neg_reg)
        begin
            mms = (v > 17'd32767) ? 16'sh7FFF : signed'(v[15:0]);
        end
        else
        begin
            mms = (v > 17'd32768) ? 16'sh8000 : signed'(16'(-v[15:0]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_total_reg  <= '0;
            wr_total_reg  <= '0;
            err_reg       <= 1'b0;
            a_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                motor_frames_reg[i] <= '0;
            end
        end
        else
        begin
            if (take)
            begin
                rd_total_reg <= rd_total_next;
                wr_total_reg <= wr_total_next;
                err_reg      <= err_next;
                for (int i = 0; i < NUM_MOTORS; i++)
                begin
                    motor_frames_reg[i] <= motor_frames_next[i];
                end
            end
            if (a_free)
            begin
                a_valid_reg <= pop_valid;
            end
            if (out_free)
            begin
                res_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_ev_reg     <= pop_frame.ev;
            a_idx_reg    <= is_read ? pop_frame.addr[0] : 1'b0;
            a_rpm_reg    <= rpm_dir;
            a_neg_reg    <= rpm_dir[15];
            a_prod_reg   <= prod;
            a_mcount_reg <= mcount;
            a_rd_reg     <= rd_total_next;
            a_wr_reg     <= wr_total_next;
            a_err_reg    <= err_next;
        end
        if (out_free && a_valid_reg)
        begin
            res_item_reg.event_res         <= a_ev_reg;
            res_item_reg.motor_index       <= a_idx_reg;
            res_item_reg.speed_rpm         <= a_rpm_reg;
            res_item_reg.speed_mms         <= mms;
            res_item_reg.motor_frame_count <= a_mcount_reg;
            res_item_reg.read_ok_count     <= a_rd_reg;
            res_item_reg.write_ok_count    <= a_wr_reg;
            res_item_reg.error_flag        <= a_err_reg;
        end
    end

endmodule

`default_nettype wire

[src/modbus_rtu_response_parser_unit.sv]
// Modbus RTU reply parser for a link shared by up to NUM_MOTORS motor drives.
// Byte channel (byte_valid/byte_ready/byte_item): one item per received byte,
// or a line gap item (func set) that returns the parser to idle from any state.
// Result channel (res_valid/res_ready/res_item): exactly one item for every
// accepted byte item, in order: the frame outcome (read ok with scaled speed,
// write ok, CRC error, byte count rejected, or none), plus running counters.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
// only while no item is in flight.
// Throughput: one item per cycle while res_ready stays high. The parser updates
// its state and the byte-wise CRC in the accept cycle; a two-entry queue feeds a
// two-stage result path (multiply, then round and saturate).
// Path: each accepted byte enters the queue, then the multiply stage register and
// the output register, which raises res_valid; the result is taken at the rising
// edge on which res_ready is high.
// Stall: when res_ready is low the result path holds, the queue fills and
// byte_ready drops; nothing is lost or repeated.
// Reset: parser idle, CRC preset, counters and error flag cleared, registers
// back to their defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_response_parser_unit #(
    parameter int NUM_MOTORS = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // byte items
    input  wire logic          byte_valid,
    output logic               byte_ready,
    input  wire mrtu_pkg::in_t  byte_item,
    // result items
    output logic               res_valid,
    input  wire logic          res_ready,
    output mrtu_pkg::out_t     res_item,
    // register writes
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [15:0]   cfg_data
);

    // configuration registers
    logic [15:0] rpm_to_mms_reg;
    logic [7:0]  read_func_reg;
    logic [7:0]  write_func_reg;
    logic [7:0]  max_count_reg;
    mrtu_pkg::cfg_t cfg;

    // parser to result path
    logic             push_valid, push_ready;
    mrtu_pkg::frame_t push_frame;
    logic             pop_valid, pop_ready;
    mrtu_pkg::frame_t pop_frame;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg.rpm_to_mms_q16  = rpm_to_mms_reg;
        cfg.read_func_code  = read_func_reg;
        cfg.write_func_code = write_func_reg;
        cfg.max_byte_count  = max_count_reg;
    end

    // take a register write; the index covers exactly the four registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpm_to_mms_reg <= mrtu_pkg::RST_RPM_TO_MMS;
            read_func_reg  <= mrtu_pkg::RST_READ_FUNC;
            write_func_reg <= mrtu_pkg::RST_WRITE_FUNC;
            max_count_reg  <= mrtu_pkg::RST_MAX_COUNT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mrtu_pkg::CFG_RPM_TO_MMS: rpm_to_mms_reg <= cfg_data;
                mrtu_pkg::CFG_READ_FUNC:  read_func_reg  <= cfg_data[7:0];
                mrtu_pkg::CFG_WRITE_FUNC: write_func_reg <= cfg_data[7:0];
                mrtu_pkg::CFG_MAX_COUNT:  max_count_reg  <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // classify bytes, track frame state and CRC
    mrtu_front #(
        .NUM_MOTORS (NUM_MOTORS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_frame (push_frame)
    );

    // decouple parser and result path
    mrtu_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_frame),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_frame)
    );

    // scale speed, advance counters, hold the result
    mrtu_back #(
        .NUM_MOTORS (NUM_MOTORS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .rpm_to_mms_q16 (cfg.rpm_to_mms_q16),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_frame      (pop_frame),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res_item       (res_item)
    );

endmodule

`default_nettype wire

[src/mrtu_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "modbus_rtu_response_parser_unit_defines.svh"

module mrtu_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           res_valid,
    input wire logic           res_ready,
    input wire mrtu_pkg::out_t res_item
);

    logic no_speed;
    logic read_res;
    logic crc_res;
    logic other_res;
    assign no_speed = (res_item.speed_rpm == 16'sd0) && (res_item.speed_mms == 16'sd0)
                   && (res_item.motor_frame_count == 16'd0) && !res_item.motor_index;
    assign read_res  = res_valid && (res_item.event_res == mrtu_pkg::EV_READ_OK);
    assign crc_res   = res_valid && (res_item.event_res == mrtu_pkg::EV_CRC_ERR);
    assign other_res = res_valid && (res_item.event_res != mrtu_pkg::EV_READ_OK);

    // a stalled result holds
    `MRTU_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_item))

    // only a good read carries speed and a motor count
    `MRTU_ASSERT_SAME(a_speed_only_on_read, other_res, no_speed)

    // a good read clears the error flag, a CRC error sets it
    `MRTU_ASSERT_SAME(a_read_clears_err, read_res, !res_item.error_flag)
    `MRTU_ASSERT_SAME(a_crc_sets_err, crc_res, res_item.error_flag)

endmodule

bind modbus_rtu_response_parser_unit mrtu_checker u_mrtu_checker (.*);

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int MOTORS      = 2;
    localparam int LATENCY_PAD = 8;     // settling wait after the last expected result
    localparam int STALL_LIMIT = 2000;  // cycles without any handshake before giving up

    // predictor view of the parser sequencer
    typedef enum logic [2:0] {
        P_IDLE, P_FUNC, P_COUNT, P_DATA, P_WRITE, P_CRCL, P_CRCH, P_PARK
    } parse_phase_t;

    logic           clk;
    logic           rst_n      = 1'b0;
    logic           byte_valid = 1'b0;
    logic           byte_ready;
    mrtu_pkg::in_t  byte_item  = '0;
    logic           res_valid;
    logic           res_ready  = 1'b0;
    mrtu_pkg::out_t res_item;
    logic           cfg_valid  = 1'b0;
    logic           cfg_ready;
    logic [1:0]     cfg_index  = mrtu_pkg::CFG_RPM_TO_MMS;
    logic [15:0]    cfg_data   = '0;

    // predictor copy of the registers
    logic [15:0]  scale_q16;
    logic [7:0]   read_code;
    logic [7:0]   write_code;
    logic [7:0]   count_limit;

    // predictor copy of the parser state
    parse_phase_t parse_phase;
    logic [7:0]   bytes_seen;
    logic [7:0]   count_field;
    logic [1:0]   slave_sel;
    logic [15:0]  speed_word;
    logic [15:0]  crc_acc;
    logic [15:0]  crc_rx;
    logic [15:0]  good_reads [MOTORS];
    logic [15:0]  read_total;
    logic [15:0]  write_total;
    logic         crc_fault;

    mrtu_pkg::out_t pending_outcomes [$];
    logic [7:0]     frame_bytes [$];
    int             accepted_items    = 0;
    int             mismatch_count    = 0;
    int             sender_idle_pct   = 0;
    int             receiver_idle_pct = 0;

    modbus_rtu_response_parser_unit #(
        .NUM_MOTORS (MOTORS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // CRC-16/MODBUS, reflected, one byte at a time
    function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] data);
        logic [15:0] c;
        c = acc ^ {8'h00, data};
        repeat (8)
            c = c[0] ? ((c >> 1) ^ mrtu_pkg::CRC_POLY) : (c >> 1);
        return c;
    endfunction

    // Scale 0.01 rpm to mm/s: round half away from zero, then clamp to 16 bits.
    function automatic logic [15:0] scale_to_mms(input int rpm);
        longint unsigned mag;
        longint          mms;
        mag = (rpm < 0) ? longint'(-rpm) : longint'(rpm);
        mms = longint'((mag * longint'(scale_q16) + 64'h8000) >> 16);
        if (rpm < 0)
            mms = -mms;
        if (mms > 32767)
            mms = 32767;
        else if (mms < -32768)
            mms = -32768;
        return mms[15:0];
    endfunction

    function automatic void reset_predictor();
        scale_q16   = mrtu_pkg::RST_RPM_TO_MMS;
        read_code   = mrtu_pkg::RST_READ_FUNC;
        write_code  = mrtu_pkg::RST_WRITE_FUNC;
        count_limit = mrtu_pkg::RST_MAX_COUNT;
        parse_phase = P_IDLE;
        bytes_seen  = '0;
        count_field = '0;
        slave_sel   = '0;
        speed_word  = '0;
        crc_acc     = mrtu_pkg::CRC_INIT;
        crc_rx      = '0;
        foreach (good_reads[i])
            good_reads[i] = '0;
        read_total  = '0;
        write_total = '0;
        crc_fault   = 1'b0;
    endfunction

    // Advance the parser by one item and return the result it produces.
    function automatic mrtu_pkg::out_t parse_byte_item(input mrtu_pkg::in_t item);
        mrtu_pkg::out_t res;
        logic [7:0]     b;
        int             rpm;
        res = '0;
        b   = item.rx_byte;
        if (item.func)
        begin
            // line gap: resync from any state, report nothing
            parse_phase = P_IDLE;
            bytes_seen  = '0;
        end
        else
        begin
            case (parse_phase)
                P_IDLE:
                begin
                    if (b >= 8'd1 && b <= MOTORS)
                    begin
                        slave_sel   = 2'(b - 8'd1);
                        crc_acc     = crc_next(mrtu_pkg::CRC_INIT, b);
                        parse_phase = P_FUNC;
                    end
                    else
                        parse_phase = P_PARK;
                end
                P_FUNC:
                begin
                    crc_acc    = crc_next(crc_acc, b);
                    bytes_seen = '0;
                    // the read code wins when both codes are equal
                    if (b == read_code)
                        parse_phase = P_COUNT;
                    else if (b == write_code)
                        parse_phase = P_WRITE;
                    else
                        parse_phase = P_PARK;
                end
                P_COUNT:
                begin
                    crc_acc     = crc_next(crc_acc, b);
                    count_field = b;
                    bytes_seen  = '0;
                    if (b > count_limit)
                    begin
                        res.event_res = mrtu_pkg::EV_COUNT_REJ;
                        parse_phase   = P_IDLE;
                    end
                    else
                        parse_phase = (b == 8'd0) ? P_CRCL : P_DATA;
                end
                P_DATA:
                begin
                    crc_acc = crc_next(crc_acc, b);
                    if (bytes_seen == 8'd0)
                        speed_word[15:8] = b;
                    else if (bytes_seen == 8'd1)
                        speed_word[7:0] = b;
                    bytes_seen = bytes_seen + 8'd1;
                    if (bytes_seen >= count_field)
                        parse_phase = P_CRCL;
                end
                P_CRCL:
                begin
                    // short replies borrow the CRC bytes for the speed word
                    if (count_field == 8'd0)
                        speed_word[15:8] = b;
                    else if (count_field == 8'd1)
                        speed_word[7:0] = b;
                    crc_rx      = {8'h00, b};
                    parse_phase = P_CRCH;
                end
                P_CRCH:
                begin
                    if (count_field == 8'd0)
                        speed_word[7:0] = b;
                    crc_rx[15:8] = b;
                    if (crc_rx == crc_acc)
                    begin
                        crc_fault  = 1'b0;
                        read_total = read_total + 16'd1;
                        rpm = int'(signed'(speed_word));
                        if (slave_sel >= MOTORS || !item.motor_enable[slave_sel])
                            rpm = 0;
                        // second drive turns the other way; the most negative value stays
                        if (slave_sel[0])
                            rpm = (rpm == -32768) ? -32768 : -rpm;
                        res.speed_rpm = rpm[15:0];
                        res.speed_mms = scale_to_mms(rpm);
                        if (slave_sel < MOTORS)
                        begin
                            good_reads[slave_sel]  = good_reads[slave_sel] + 16'd1;
                            res.motor_frame_count  = good_reads[slave_sel];
                        end
                        res.motor_index = slave_sel[0];
                        res.event_res   = mrtu_pkg::EV_READ_OK;
                    end
                    else
                    begin
                        crc_fault     = 1'b1;
                        res.event_res = mrtu_pkg::EV_CRC_ERR;
                    end
                    bytes_seen  = '0;
                    parse_phase = P_IDLE;
                end
                P_WRITE:
                begin
                    bytes_seen = bytes_seen + 8'd1;
                    if (bytes_seen <= mrtu_pkg::WRITE_DATA_BYTES)
                        crc_acc = crc_next(crc_acc, b);
                    else if (bytes_seen == mrtu_pkg::WRITE_DATA_BYTES + 8'd1)
                        crc_rx = {8'h00, b};
                    else
                    begin
                        crc_rx[15:8] = b;
                        if (crc_rx == crc_acc)
                        begin
                            write_total   = write_total + 16'd1;
                            res.event_res = mrtu_pkg::EV_WRITE_OK;
                        end
                        else
                        begin
                            crc_fault     = 1'b1;
                            res.event_res = mrtu_pkg::EV_CRC_ERR;
                        end
                        bytes_seen  = '0;
                        parse_phase = P_IDLE;
                    end
                end
                default:
                begin
                    // parked: drop bytes until a gap
                end
            endcase
        end
        res.read_ok_count  = read_total;
        res.write_ok_count = write_total;
        res.error_flag     = crc_fault;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Byte channel and register writes
    // ------------------------------------------------------------------

    function automatic mrtu_pkg::in_t make_item(input logic gap, input logic [7:0] b,
                                                input logic [1:0] en);
        mrtu_pkg::in_t item;
        item.func         = gap;
        item.rx_byte      = b;
        item.motor_enable = en;
        return item;
    endfunction

    // Offer one item, hold it until taken, then queue its expected result.
    task automatic send_item(input mrtu_pkg::in_t item);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= item;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        // bytes the parked parser drops do not count toward the traffic budget
        if (item.func || parse_phase != P_PARK)
            accepted_items++;
        pending_outcomes.push_back(parse_byte_item(item));
    endtask

    task automatic send_gap();
        send_item(make_item(1'b1, 8'($urandom), 2'($urandom)));
    endtask

    task automatic send_frame_bytes(input logic [1:0] en);
        foreach (frame_bytes[i])
            send_item(make_item(1'b0, frame_bytes[i], en));
    endtask

    // Drop valid, wait for every expected result, then let the pipe settle.
    task automatic wait_until_drained();
        byte_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (LATENCY_PAD)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            mrtu_pkg::CFG_RPM_TO_MMS: scale_q16   = value;
            mrtu_pkg::CFG_READ_FUNC:  read_code   = value[7:0];
            mrtu_pkg::CFG_WRITE_FUNC: write_code  = value[7:0];
            mrtu_pkg::CFG_MAX_COUNT:  count_limit = value[7:0];
            default: ;
        endcase
    endtask

    // Only call with the block drained.
    task automatic program_registers(input logic [15:0] factor, input logic [7:0] rd_code,
                                     input logic [7:0] wr_code, input logic [7:0] count_max);
        write_register(mrtu_pkg::CFG_RPM_TO_MMS, factor);
        write_register(mrtu_pkg::CFG_READ_FUNC, {8'h00, rd_code});
        write_register(mrtu_pkg::CFG_WRITE_FUNC, {8'h00, wr_code});
        write_register(mrtu_pkg::CFG_MAX_COUNT, {8'h00, count_max});
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Frame builders
    // ------------------------------------------------------------------

    function automatic void start_frame(input logic [7:0] slave, input logic [7:0] code);
        frame_bytes.delete();
        frame_bytes.push_back(slave);
        frame_bytes.push_back(code);
    endfunction

    // Append the CRC, low byte first.
    function automatic void seal_frame();
        logic [15:0] c;
        c = mrtu_pkg::CRC_INIT;
        foreach (frame_bytes[i])
            c = crc_next(c, frame_bytes[i]);
        frame_bytes.push_back(c[7:0]);
        frame_bytes.push_back(c[15:8]);
    endfunction

    function automatic void build_read(input logic [7:0] slave, input int count,
                                       input logic [15:0] word);
        start_frame(slave, read_code);
        frame_bytes.push_back(8'(count));
        for (int i = 0; i < count; i++)
            frame_bytes.push_back(8'($urandom));
        if (count >= 1)
            frame_bytes[3] = word[15:8];
        if (count >= 2)
            frame_bytes[4] = word[7:0];
        seal_frame();
    endfunction

    function automatic void build_write(input logic [7:0] slave);
        start_frame(slave, write_code);
        for (int i = 0; i < mrtu_pkg::WRITE_DATA_BYTES; i++)
            frame_bytes.push_back(8'($urandom));
        seal_frame();
    endfunction

    // Favor the sign and range corners of the speed register.
    function automatic logic [15:0] pick_speed_word();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0001;
            4: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly short replies; now and then up to the limit.
    function automatic int pick_count();
        int limit;
        int roll;
        limit = count_limit;
        roll  = $urandom_range(99);
        if (limit == 0)
            return 0;
        if (roll < 80)
            return $urandom_range((limit < 6) ? limit : 6);
        if (roll < 97)
            return $urandom_range((limit < 16) ? limit : 16);
        return $urandom_range(limit);
    endfunction

    // One random frame: mostly well formed, the rest broken or noise.
    task automatic send_random_frame();
        int         kind;
        int         pos;
        int         cut;
        logic [7:0] slave;
        logic [7:0] b;
        logic [1:0] en;
        en    = 2'($urandom);
        slave = 8'($urandom_range(MOTORS, 1));
        kind  = $urandom_range(99);
        if ($urandom_range(99) < 30)
            send_gap();
        if (kind < 50 || (kind >= 75 && kind < 82 && count_limit == 8'hFF))
        begin
            build_read(slave, pick_count(), pick_speed_word());
            send_frame_bytes(en);
        end
        else if (kind < 65)
        begin
            build_write(slave);
            send_frame_bytes(en);
        end
        else if (kind < 75)
        begin
            // flip one bit past the header, then resync
            if (kind < 70)
                build_read(slave, pick_count(), pick_speed_word());
            else
                build_write(slave);
            pos = $urandom_range(frame_bytes.size() - 1, 2);
            frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(7));
            send_frame_bytes(en);
            send_gap();
        end
        else if (kind < 82)
        begin
            start_frame(slave, read_code);
            frame_bytes.push_back(8'($urandom_range(255, count_limit + 1)));
            send_frame_bytes(en);
        end
        else if (kind < 89)
        begin
            // bad address or bad function code, trailing noise, then resync
            if ($urandom_range(1))
            begin
                b = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255, MOTORS + 1));
                frame_bytes = '{b};
            end
            else
            begin
                do
                    b = 8'($urandom);
                while (b == read_code || b == write_code);
                start_frame(slave, b);
            end
            repeat ($urandom_range(4))
                frame_bytes.push_back(8'($urandom));
            send_frame_bytes(en);
            send_gap();
        end
        else if (kind < 95)
        begin
            // cut a good frame short, then resync
            if ($urandom_range(1))
                build_read(slave, pick_count(), pick_speed_word());
            else
                build_write(slave);
            cut = $urandom_range(frame_bytes.size() - 1, 1);
            frame_bytes = frame_bytes[0:cut-1];
            send_frame_bytes(en);
            send_gap();
        end
        else
        begin
            frame_bytes.delete();
            repeat ($urandom_range(6, 1))
                frame_bytes.push_back(8'($urandom));
            send_frame_bytes(en);
            send_gap();
        end
    endtask

    task automatic run_traffic(input int count);
        int target;
        target = accepted_items + count;
        while (accepted_items < target)
            send_random_frame();
        wait_until_drained();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_frames();
        // bad slave address parks the parser; the next byte is dropped
        frame_bytes = '{8'h00, 8'hFF};
        send_frame_bytes(2'b11);
        send_gap();
        // unknown function code parks as well
        frame_bytes = '{8'h01, 8'h55};
        send_frame_bytes(2'b11);
        send_gap();
        // byte count above the limit: rejected, parser back to idle on its own
        frame_bytes = '{8'h02, read_code, count_limit + 8'd1};
        send_frame_bytes(2'b11);
        // empty read: the speed word is built from the CRC bytes
        build_read(8'd1, 0, 16'h0000);
        send_frame_bytes(2'b01);
        // most negative speed on the second drive survives the negation
        build_read(8'd2, 2, 16'h8000);
        send_frame_bytes(2'b10);
        // write echo with a broken CRC high byte sets the error flag
        build_write(8'd1);
        frame_bytes[7] = frame_bytes[7] ^ 8'h01;
        send_frame_bytes(2'b00);
        // line gap in the middle of a read header
        frame_bytes = '{8'h01, read_code};
        send_frame_bytes(2'b11);
        send_gap();
        wait_until_drained();
    endtask

    task automatic test_reset_registers();
        run_traffic(200);
    endtask

    // zero factor, header-only reads
    task automatic test_zero_factor_empty_reads();
        program_registers(16'h0000, mrtu_pkg::RST_READ_FUNC, mrtu_pkg::RST_WRITE_FUNC, 8'h00);
        run_traffic(200);
    endtask

    // full factor, extreme function codes, any byte count
    task automatic test_full_factor_wide_counts();
        program_registers(16'hFFFF, 8'hFF, 8'h00, 8'hFF);
        run_traffic(250);
    endtask

    // read and write share one code: the read path must win
    task automatic test_shared_func_code();
        logic [7:0] code;
        code = 8'($urandom);
        program_registers(16'($urandom), code, code, 8'd4);
        run_traffic(200);
    endtask

    // factor of one half puts odd speeds exactly on the rounding boundary
    task automatic test_half_factor_rounding();
        program_registers(16'h8000, mrtu_pkg::RST_READ_FUNC, 8'h10, mrtu_pkg::RST_MAX_COUNT);
        run_traffic(300);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %h, got %h", what, want, got);
    endtask

    task automatic compare_outcome(input mrtu_pkg::out_t want, input mrtu_pkg::out_t got);
        if (got.event_res !== want.event_res)
            flag_mismatch("event_res", 16'(want.event_res), 16'(got.event_res));
        if (got.motor_index !== want.motor_index)
            flag_mismatch("motor_index", 16'(want.motor_index), 16'(got.motor_index));
        if (got.speed_rpm !== want.speed_rpm)
            flag_mismatch("speed_rpm", want.speed_rpm, got.speed_rpm);
        if (got.speed_mms !== want.speed_mms)
            flag_mismatch("speed_mms", want.speed_mms, got.speed_mms);
        if (got.motor_frame_count !== want.motor_frame_count)
            flag_mismatch("motor_frame_count", want.motor_frame_count, got.motor_frame_count);
        if (got.read_ok_count !== want.read_ok_count)
            flag_mismatch("read_ok_count", want.read_ok_count, got.read_ok_count);
        if (got.write_ok_count !== want.write_ok_count)
            flag_mismatch("write_ok_count", want.write_ok_count, got.write_ok_count);
        if (got.error_flag !== want.error_flag)
            flag_mismatch("error_flag", 16'(want.error_flag), 16'(got.error_flag));
    endtask

    // Sample each result at the edge that takes it, then pick the next ready level.
    initial
    begin : result_monitor
        mrtu_pkg::out_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && res_ready)
            begin
                got = res_item;
                if (pending_outcomes.size() == 0)
                    flag_mismatch("result with nothing pending", 16'h0000, 16'(got.event_res));
                else
                    compare_outcome(pending_outcomes.pop_front(), got);
            end
            res_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // End the run when no channel has moved an item for too long.
    initial
    begin : stall_watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((byte_valid && byte_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        reset_predictor();
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver stalls heavily
        sender_idle_pct   = 33;
        receiver_idle_pct = 69;
        test_directed_frames();
        test_reset_registers();
        test_zero_factor_empty_reads();

        // swap the pressure
        sender_idle_pct   = 69;
        receiver_idle_pct = 33;
        test_full_factor_wide_counts();
        test_shared_func_code();

        // back to back on both sides
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_half_factor_rounding();

        if (mismatch_count == 0 && pending_outcomes.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[modbus_rtu_response_parser_unit.f]
+incdir+src
src/mrtu_pkg.sv
src/mrtu_fifo.sv
src/mrtu_front.sv
src/mrtu_back.sv
src/modbus_rtu_response_parser_unit.sv
src/mrtu_checker.sv
bench/tb_top.sv
